// ===== hdl/fts_pkg.sv =====
// Shared types and constants of the FLV tag stream splicer.
package fts_pkg;

    localparam int unsigned FILE_HDR_LEN = 13;
    localparam int unsigned TAG_HDR_LEN  = 11;
    localparam int unsigned TAIL_LEN     = 4;
    localparam int unsigned COUNT_W      = 25;
    localparam int unsigned IDX_W        = 4;

    localparam logic [7:0] TAG_AUDIO = 8'h08;
    localparam logic [7:0] TAG_VIDEO = 8'h09;
    localparam logic [7:0] MAGIC_F   = 8'h46;
    localparam logic [7:0] MAGIC_L   = 8'h4C;
    localparam logic [7:0] MAGIC_V   = 8'h56;

    typedef enum logic [2:0] {
        PH_FILE_HDR,
        PH_TAG_HDR,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DROP
    } phase_t;

    // One run of output bytes: a file header, a tag header or a payload byte.
    typedef struct packed {
        logic [FILE_HDR_LEN-1:0][7:0] data;
        logic [IDX_W-1:0]             len;
    } run_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== hdl/fts_in_if.sv =====
// Input channel: raw file bytes with a file start flag.
interface fts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

// ===== hdl/fts_out_if.sv =====
// Output channel: bytes of the spliced stream with an end-of-run flag.
interface fts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== hdl/fts_front.sv =====
// Front end: parses file and tag headers, rebases timestamps, builds output runs.
module fts_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              file_start,
    output logic              push,
    output fts_pkg::run_t     entry
);

    fts_pkg::phase_t                   phase_reg, phase_next;
    logic [fts_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [fts_pkg::FILE_HDR_LEN-1:0][7:0] buf_reg;
    logic [31:0]                       time_base_reg, time_base_next;
    logic [31:0]                       last_stamp_reg, last_stamp_next;
    logic                              stamp_seen_reg, stamp_seen_next;
    logic                              hdr_written_reg, hdr_written_next;
    logic                              script_seen_reg, script_seen_next;

    fts_pkg::phase_t                   eff_phase;
    logic [fts_pkg::COUNT_W-1:0]       eff_count;
    logic [fts_pkg::COUNT_W-1:0]       count_dec;
    logic [fts_pkg::IDX_W-1:0]         hdr_idx;
    logic                              file_done;
    logic                              tag_done;
    logic                              magic_ok;
    logic                              is_av;
    logic [23:0]                       dlen;
    logic [31:0]                       stamp;

    // A file start restarts header parsing on this very byte.
    assign eff_phase = file_start ? fts_pkg::PH_FILE_HDR : phase_reg;
    assign eff_count = file_start ? '0 : count_reg;
    assign count_dec = eff_count - fts_pkg::COUNT_W'(1);
    assign hdr_idx   = eff_count[fts_pkg::IDX_W-1:0];

    assign file_done = (eff_phase == fts_pkg::PH_FILE_HDR)
                       && (hdr_idx == fts_pkg::IDX_W'(fts_pkg::FILE_HDR_LEN - 1));
    assign tag_done  = (eff_phase == fts_pkg::PH_TAG_HDR)
                       && (hdr_idx == fts_pkg::IDX_W'(fts_pkg::TAG_HDR_LEN - 1));
    assign magic_ok  = (buf_reg[0] == fts_pkg::MAGIC_F) && (buf_reg[1] == fts_pkg::MAGIC_L)
                       && (buf_reg[2] == fts_pkg::MAGIC_V);
    assign is_av     = (buf_reg[0] == fts_pkg::TAG_AUDIO) || (buf_reg[0] == fts_pkg::TAG_VIDEO);
    assign dlen      = {buf_reg[1], buf_reg[2], buf_reg[3]};
    assign stamp     = {buf_reg[7], buf_reg[4], buf_reg[5], buf_reg[6]} + time_base_reg;

    // Next state
    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        time_base_next   = time_base_reg;
        last_stamp_next  = last_stamp_reg;
        stamp_seen_next  = stamp_seen_reg;
        hdr_written_next = hdr_written_reg;
        script_seen_next = script_seen_reg;
        if (accept)
        begin
            phase_next = eff_phase;
            count_next = eff_count;
            if (file_start)
            begin
                stamp_seen_next = 1'b0;
                if (stamp_seen_reg)
                begin
                    time_base_next = last_stamp_reg;
                end
            end
            unique case (eff_phase)
                fts_pkg::PH_FILE_HDR:
                begin
                    if (file_done)
                    begin
                        count_next = '0;
                        if (magic_ok)
                        begin
                            phase_next       = fts_pkg::PH_TAG_HDR;
                            hdr_written_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = fts_pkg::PH_DROP;
                        end
                    end
                    else
                    begin
                        count_next = eff_count + fts_pkg::COUNT_W'(1);
                    end
                end
                fts_pkg::PH_TAG_HDR:
                begin
                    if (tag_done)
                    begin
                        count_next = {1'b0, dlen} + fts_pkg::COUNT_W'(fts_pkg::TAIL_LEN);
                        if (is_av)
                        begin
                            last_stamp_next = stamp;
                            stamp_seen_next = 1'b1;
                            phase_next      = fts_pkg::PH_PAYLOAD;
                        end
                        else if (script_seen_reg)
                        begin
                            phase_next = fts_pkg::PH_SKIP;
                        end
                        else
                        begin
                            script_seen_next = 1'b1;
                            phase_next       = fts_pkg::PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        count_next = eff_count + fts_pkg::COUNT_W'(1);
                    end
                end
                fts_pkg::PH_PAYLOAD, fts_pkg::PH_SKIP:
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        phase_next = fts_pkg::PH_TAG_HDR;
                    end
                end
                fts_pkg::PH_DROP:
                begin
                    phase_next = fts_pkg::PH_DROP;
                end
                default:
                begin
                    phase_next = fts_pkg::PH_DROP;
                end
            endcase
        end
    end

    // Outputs: one run request per accepted byte at most
    always_comb
    begin
        push       = 1'b0;
        entry.data = buf_reg;
        entry.len  = fts_pkg::IDX_W'(1);
        unique case (eff_phase)
            fts_pkg::PH_FILE_HDR:
            begin
                entry.data[hdr_idx] = in_byte;
                entry.len           = fts_pkg::IDX_W'(fts_pkg::FILE_HDR_LEN);
                push                = accept && file_done && magic_ok && !hdr_written_reg;
            end
            fts_pkg::PH_TAG_HDR:
            begin
                entry.data[hdr_idx] = in_byte;
                if (is_av)
                begin
                    entry.data[4] = stamp[23:16];
                    entry.data[5] = stamp[15:8];
                    entry.data[6] = stamp[7:0];
                    entry.data[7] = stamp[31:24];
                end
                entry.len = fts_pkg::IDX_W'(fts_pkg::TAG_HDR_LEN);
                push      = accept && tag_done && (is_av || !script_seen_reg);
            end
            fts_pkg::PH_PAYLOAD:
            begin
                entry.data[0] = in_byte;
                push          = accept;
            end
            fts_pkg::PH_SKIP, fts_pkg::PH_DROP:
            begin
                push = 1'b0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= fts_pkg::PH_FILE_HDR;
            count_reg       <= '0;
            time_base_reg   <= '0;
            last_stamp_reg  <= '0;
            stamp_seen_reg  <= 1'b0;
            hdr_written_reg <= 1'b0;
            script_seen_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            time_base_reg   <= time_base_next;
            last_stamp_reg  <= last_stamp_next;
            stamp_seen_reg  <= stamp_seen_next;
            hdr_written_reg <= hdr_written_next;
            script_seen_reg <= script_seen_next;
        end
    end

    // Header buffer holds header bytes only, no reset
    always_ff @(posedge clk)
    begin
        if (accept && ((eff_phase == fts_pkg::PH_FILE_HDR)
                       || (eff_phase == fts_pkg::PH_TAG_HDR)))
        begin
            buf_reg[hdr_idx] <= in_byte;
        end
    end

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fts_pkg::PH_PAYLOAD || phase_reg == fts_pkg::PH_SKIP)
        |-> (count_reg != '0))
        else $error("payload phase with zero bytes left");

    a_tag_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fts_pkg::PH_TAG_HDR)
        |-> (count_reg < fts_pkg::COUNT_W'(fts_pkg::TAG_HDR_LEN)))
        else $error("tag header index out of range");

endmodule

// ===== hdl/fts_queue.sv =====
// Run queue between the header parser and the byte serializer.
module fts_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fts_pkg::run_t       entry,
    input  logic                pop,
    output fts_pkg::run_t       head,
    output fts_pkg::q_status_t  status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    fts_pkg::run_t     mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.full && push))
        else $error("run queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.empty && pop))
        else $error("run queue read while empty");

endmodule

// ===== hdl/fts_back.sv =====
// Back end: serializes queued runs onto the output channel one byte a cycle while the channel is ready.
module fts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  fts_pkg::run_t       head,
    input  fts_pkg::q_status_t  status,
    output logic                pop,
    fts_out_if.source           spliced
);

    logic [fts_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      last;

    assign last             = (idx_reg == head.len - fts_pkg::IDX_W'(1));
    assign spliced.valid    = !status.empty;
    assign spliced.out_byte = head.data[idx_reg];
    assign spliced.run_last = last;
    assign pop              = spliced.valid && spliced.ready && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (spliced.valid && spliced.ready)
        begin
            idx_next = last ? '0 : idx_reg + fts_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        spliced.valid |-> (idx_reg < head.len))
        else $error("byte index past end of run");

endmodule

// ===== hdl/flv_tag_stream_splicer.sv =====
// Top level of the FLV tag stream splicer: parser, run queue and serializer.
//
//   channel   dir   payload                  meaning
//   raw       in    in_byte, file_start      bytes of the input files
//   spliced   out   out_byte, run_last       bytes of the joined stream
//
// The parser takes one input byte per cycle while the run queue has room.
// A completed file header (13 bytes), tag header (11 bytes) or payload byte
// becomes one queue entry; the serializer drains entries one byte per cycle
// while spliced.ready is high. Header runs drain while payload bytes queue up
// behind them; input stalls only when all QUEUE_DEPTH entries are occupied.
// Reset returns to the file header phase with an empty queue and zero time base.
module flv_tag_stream_splicer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    fts_in_if.sink    raw,
    fts_out_if.source spliced
);

    logic               accept;
    logic               push;
    logic               pop;
    fts_pkg::run_t      entry;
    fts_pkg::run_t      head;
    fts_pkg::q_status_t status;

    assign raw.ready = !status.full;
    assign accept    = raw.valid && raw.ready;

    fts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (raw.in_byte),
        .file_start (raw.file_start),
        .push       (push),
        .entry      (entry)
    );

    fts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .entry  (entry),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    fts_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .status  (status),
        .pop     (pop),
        .spliced (spliced)
    );

endmodule
